// File: rtl/meg_pkg.sv
package meg_pkg;

	localparam int RADIUS_BITS_DEF = 10;
	localparam int COORD_BITS_DEF  = 12;
	localparam int COLOR_W         = 8;
	localparam int CFG_IDX_W       = 3;
	localparam int CFG_DATA_W      = 16;

	localparam logic [CFG_IDX_W-1:0] REG_CENTER_X    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RADIUS_X    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RADIUS_Y    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PIXEL_COLOR = 3'd4;

	typedef struct packed {
		logic load;
		logic done;
	} emit_ctl_t;

endpackage

// File: rtl/meg_intf.sv
interface meg_step_if;
	logic valid;
	logic ready;
	logic restart;

	modport source (output valid, output restart, input ready);
	modport sink (input valid, input restart, output ready);
endinterface

interface meg_pix_if import meg_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
);
	logic                      valid;
	logic                      ready;
	logic signed [COORD_BITS:0] pixel_x;
	logic signed [COORD_BITS:0] pixel_y;
	logic [COLOR_W-1:0]         color;
	logic                      last;
	logic                      done_res;

	modport source (output valid, output pixel_x, output pixel_y, output color,
		output last, output done_res, input ready);
	modport sink (input valid, input pixel_x, input pixel_y, input color,
		input last, input done_res, output ready);
endinterface

interface meg_cfg_if import meg_pkg::*;;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// File: rtl/midpoint_ellipse_generator.sv
// Midpoint ellipse rasterizer for an axis-aligned ellipse.
// Channels: cfg writes center, radii and color (index 0..4, others ignored);
// step carries one item with restart; pix delivers pixel items.
// A step with restart = 1 begins at the top point, restart = 0 advances one
// point. Each point gives four pixel items, mirrored about the center, the
// fourth with last set. Once the ellipse is complete, each step gives a
// single item with done_res and last set and zero coordinates.
// One shared 2*RADIUS_BITS+3 bit multiplier and a small sequencer do all
// arithmetic; squares of the radii are formed again on every step.
// After restart the sequencer first sets up the decision value, and at the
// switch into the second region it computes it anew. step.ready is low
// while the sequencer works on a step, so a new step is taken only once the
// last one has left the sequencer. The four pixel items leave from an output
// stage, one per cycle while pix.ready is high, in parallel with the
// decision update of the same step.
// A stalled receiver holds the output stage; the sequencer waits only when
// the next step needs the output stage and it is still full.
// Reset clears the configuration and leaves the ellipse finished, so
// steps give done items until the first restart. cfg.ready is always high.
module midpoint_ellipse_generator import meg_pkg::*; #(
	parameter int RADIUS_BITS = RADIUS_BITS_DEF,
	parameter int COORD_BITS  = COORD_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	meg_cfg_if.sink   cfg,
	meg_step_if.sink  step,
	meg_pix_if.source pix
);

	localparam int OW = RADIUS_BITS + 2;

	logic signed [COORD_BITS-1:0] cx_q;
	logic signed [COORD_BITS-1:0] cy_q;
	logic [RADIUS_BITS-1:0]       rx_q;
	logic [RADIUS_BITS-1:0]       ry_q;
	logic [COLOR_W-1:0]           col_q;
	emit_ctl_t                    emit_ctl;
	logic                         emit_busy;
	logic signed [OW-1:0]         x;
	logic signed [OW-1:0]         y;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q  <= '0;
			cy_q  <= '0;
			rx_q  <= '0;
			ry_q  <= '0;
			col_q <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_CENTER_X:    cx_q  <= cfg.data[COORD_BITS-1:0];
				REG_CENTER_Y:    cy_q  <= cfg.data[COORD_BITS-1:0];
				REG_RADIUS_X:    rx_q  <= cfg.data[RADIUS_BITS-1:0];
				REG_RADIUS_Y:    ry_q  <= cfg.data[RADIUS_BITS-1:0];
				REG_PIXEL_COLOR: col_q <= cfg.data[COLOR_W-1:0];
				default: begin
				end
			endcase
		end
	end

	meg_seq #(.RADIUS_BITS(RADIUS_BITS)) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (step.valid),
		.in_restart (step.restart),
		.in_ready   (step.ready),
		.rx         (rx_q),
		.ry         (ry_q),
		.emit_busy  (emit_busy),
		.emit_ctl   (emit_ctl),
		.x_out      (x),
		.y_out      (y)
	);

	meg_emit #(.RADIUS_BITS(RADIUS_BITS), .COORD_BITS(COORD_BITS)) u_emit (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (emit_ctl),
		.x      (x),
		.y      (y),
		.cx     (cx_q),
		.cy     (cy_q),
		.col    (col_q),
		.busy   (emit_busy),
		.pix    (pix)
	);

endmodule

// File: rtl/meg_mul.sv
module meg_mul import meg_pkg::*; #(
	parameter int MW = 2 * RADIUS_BITS_DEF + 3
) (
	input  logic                   clk,
	input  logic signed [MW-1:0]   a,
	input  logic signed [MW-1:0]   b,
	output logic signed [2*MW-1:0] prod_q
);

	always_ff @(posedge clk) begin
		prod_q <= a * b;
	end

endmodule

// File: rtl/meg_seq.sv
module meg_seq import meg_pkg::*; #(
	parameter int RADIUS_BITS = RADIUS_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  logic                         in_restart,
	output logic                         in_ready,
	input  logic [RADIUS_BITS-1:0]       rx,
	input  logic [RADIUS_BITS-1:0]       ry,
	input  logic                         emit_busy,
	output emit_ctl_t                    emit_ctl,
	output logic signed [RADIUS_BITS+1:0] x_out,
	output logic signed [RADIUS_BITS+1:0] y_out
);

	localparam int OW  = RADIUS_BITS + 2;
	localparam int MW  = 2 * RADIUS_BITS + 3;
	localparam int DW  = 2 * MW;
	localparam int R2W = 2 * RADIUS_BITS;

	localparam logic [4:0] ST_IDLE  = 5'd0;
	localparam logic [4:0] ST_SQX   = 5'd1;
	localparam logic [4:0] ST_SQY   = 5'd2;
	localparam logic [4:0] ST_SQR   = 5'd3;
	localparam logic [4:0] ST_INIT  = 5'd4;
	localparam logic [4:0] ST_CHK   = 5'd5;
	localparam logic [4:0] ST_CMP1  = 5'd6;
	localparam logic [4:0] ST_CMP2  = 5'd7;
	localparam logic [4:0] ST_T1    = 5'd8;
	localparam logic [4:0] ST_T2    = 5'd9;
	localparam logic [4:0] ST_T3    = 5'd10;
	localparam logic [4:0] ST_T4    = 5'd11;
	localparam logic [4:0] ST_T5    = 5'd12;
	localparam logic [4:0] ST_T6    = 5'd13;
	localparam logic [4:0] ST_R2CHK = 5'd14;
	localparam logic [4:0] ST_EMIT  = 5'd15;
	localparam logic [4:0] ST_U0    = 5'd16;
	localparam logic [4:0] ST_U1    = 5'd17;
	localparam logic [4:0] ST_U2    = 5'd18;
	localparam logic [4:0] ST_U3    = 5'd19;
	localparam logic [4:0] ST_V0    = 5'd20;
	localparam logic [4:0] ST_V1    = 5'd21;
	localparam logic [4:0] ST_V2    = 5'd22;
	localparam logic [4:0] ST_V3    = 5'd23;
	localparam logic [4:0] ST_DONE  = 5'd24;

	logic [4:0]             st_q;
	logic                   rs_q;
	logic                   r2_q;
	logic                   fin_q;
	logic                   dec_q;
	logic [R2W-1:0]         rx2_q;
	logic [R2W-1:0]         ry2_q;
	logic signed [OW-1:0]   x_q;
	logic signed [OW-1:0]   y_q;
	logic signed [DW-1:0]   p_q;
	logic signed [DW-1:0]   t_q;
	logic signed [MW-1:0]   mul_a;
	logic signed [MW-1:0]   mul_b;
	logic signed [DW-1:0]   prod;
	logic signed [MW-1:0]   prod_lo;
	logic signed [OW:0]     tx;
	logic signed [OW-1:0]   y_m1;
	logic                   p_neg;
	logic                   p_le0;

	meg_mul #(.MW(MW)) u_mul (
		.clk    (clk),
		.a      (mul_a),
		.b      (mul_b),
		.prod_q (prod)
	);

	assign prod_lo = prod[MW-1:0];
	assign tx      = {x_q, 1'b1};
	assign y_m1    = y_q - OW'(1);
	assign p_neg   = p_q[DW-1];
	assign p_le0   = p_neg || (p_q == '0);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (st_q)
			ST_SQX: begin
				mul_a = MW'(rx);
				mul_b = MW'(rx);
			end
			ST_SQY: begin
				mul_a = MW'(ry);
				mul_b = MW'(ry);
			end
			ST_SQR: begin
				mul_a = MW'(rx2_q);
				mul_b = MW'(ry);
			end
			ST_CHK, ST_U1, ST_V2: begin
				mul_a = MW'(ry2_q);
				mul_b = MW'(x_q);
			end
			ST_CMP1, ST_U2, ST_V1: begin
				mul_a = MW'(rx2_q);
				mul_b = MW'(y_q);
			end
			ST_CMP2: begin
				mul_a = MW'(ry);
				mul_b = MW'(tx);
			end
			ST_T1, ST_T3, ST_T5: begin
				mul_a = prod_lo;
				mul_b = prod_lo;
			end
			ST_T2: begin
				mul_a = MW'(rx);
				mul_b = MW'(y_m1);
			end
			ST_T4: begin
				mul_a = MW'(rx);
				mul_b = MW'(ry);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= ST_IDLE;
			rs_q  <= 1'b0;
			r2_q  <= 1'b0;
			fin_q <= 1'b1;
			dec_q <= 1'b0;
		end else begin
			unique case (st_q)
				ST_IDLE: begin
					if (in_valid) begin
						rs_q <= in_restart;
						st_q <= ST_SQX;
					end
				end
				ST_SQX: st_q <= ST_SQY;
				ST_SQY: st_q <= ST_SQR;
				ST_SQR: begin
					if (rs_q) begin
						fin_q <= 1'b0;
						r2_q  <= 1'b0;
						st_q  <= ST_INIT;
					end else begin
						st_q <= ST_CHK;
					end
				end
				ST_INIT: st_q <= ST_CHK;
				ST_CHK: begin
					if (fin_q) begin
						st_q <= ST_DONE;
					end else if (r2_q) begin
						st_q <= ST_R2CHK;
					end else begin
						st_q <= ST_CMP1;
					end
				end
				ST_CMP1: st_q <= ST_CMP2;
				ST_CMP2: begin
					if (!y_q[OW-1] && (t_q <= prod)) begin
						st_q <= ST_EMIT;
					end else begin
						st_q <= ST_T1;
					end
				end
				ST_T1: st_q <= ST_T2;
				ST_T2: st_q <= ST_T3;
				ST_T3: st_q <= ST_T4;
				ST_T4: st_q <= ST_T5;
				ST_T5: st_q <= ST_T6;
				ST_T6: begin
					r2_q <= 1'b1;
					st_q <= ST_R2CHK;
				end
				ST_R2CHK: begin
					if (y_q[OW-1]) begin
						fin_q <= 1'b1;
						st_q  <= ST_DONE;
					end else begin
						st_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (!emit_busy) begin
						st_q <= r2_q ? ST_V0 : ST_U0;
					end
				end
				ST_U0: begin
					dec_q <= !p_neg;
					st_q  <= ST_U1;
				end
				ST_U1: st_q <= ST_U2;
				ST_U2: st_q <= dec_q ? ST_U3 : ST_IDLE;
				ST_U3: st_q <= ST_IDLE;
				ST_V0: begin
					dec_q <= p_le0;
					st_q  <= ST_V1;
				end
				ST_V1: st_q <= ST_V2;
				ST_V2: st_q <= dec_q ? ST_V3 : ST_IDLE;
				ST_V3: st_q <= ST_IDLE;
				ST_DONE: begin
					if (!emit_busy) begin
						st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (st_q)
			ST_SQY: rx2_q <= prod[R2W-1:0];
			ST_SQR: begin
				ry2_q <= prod[R2W-1:0];
				if (rs_q) begin
					x_q <= '0;
					y_q <= OW'(ry);
				end
			end
			ST_INIT: p_q <= (DW'(ry2_q) << 2) + DW'(rx2_q) - (prod <<< 2);
			ST_CMP1: t_q <= prod;
			ST_T2:   p_q <= prod;
			ST_T4:   p_q <= p_q + (prod <<< 2);
			ST_T6:   p_q <= p_q - (prod <<< 2);
			ST_U0: begin
				x_q <= x_q + OW'(1);
				if (!p_neg) begin
					y_q <= y_m1;
				end
			end
			ST_U2:   p_q <= p_q + (prod <<< 3) + (DW'(ry2_q) << 2);
			ST_U3:   p_q <= p_q - (prod <<< 3);
			ST_V0: begin
				y_q <= y_m1;
				if (p_le0) begin
					x_q <= x_q + OW'(1);
				end
			end
			ST_V2:   p_q <= p_q - (prod <<< 3) + (DW'(rx2_q) << 2);
			ST_V3:   p_q <= p_q + (prod <<< 3);
			default: begin
			end
		endcase
	end

	assign in_ready      = (st_q == ST_IDLE);
	assign emit_ctl.load = ((st_q == ST_EMIT) || (st_q == ST_DONE)) && !emit_busy;
	assign emit_ctl.done = (st_q == ST_DONE);
	assign x_out         = x_q;
	assign y_out         = y_q;

endmodule

// File: rtl/meg_emit.sv
module meg_emit import meg_pkg::*; #(
	parameter int RADIUS_BITS = RADIUS_BITS_DEF,
	parameter int COORD_BITS  = COORD_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  emit_ctl_t                     ctl,
	input  logic signed [RADIUS_BITS+1:0] x,
	input  logic signed [RADIUS_BITS+1:0] y,
	input  logic signed [COORD_BITS-1:0]  cx,
	input  logic signed [COORD_BITS-1:0]  cy,
	input  logic [COLOR_W-1:0]            col,
	output logic                          busy,
	meg_pix_if.source                     pix
);

	localparam int OW = RADIUS_BITS + 2;
	localparam int PW = COORD_BITS + 1;
	localparam int SW = ((PW > OW) ? PW : OW) + 1;

	logic                         act_q;
	logic [1:0]                   k_q;
	logic                         done_q;
	logic signed [OW-1:0]         x_q;
	logic signed [OW-1:0]         y_q;
	logic signed [COORD_BITS-1:0] cx_q;
	logic signed [COORD_BITS-1:0] cy_q;
	logic [COLOR_W-1:0]           col_q;
	logic                         plus_x;
	logic                         plus_y;
	logic signed [SW-1:0]         sx;
	logic signed [SW-1:0]         sy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q  <= 1'b0;
			k_q    <= '0;
			done_q <= 1'b0;
		end else if (!act_q) begin
			if (ctl.load) begin
				act_q  <= 1'b1;
				k_q    <= '0;
				done_q <= ctl.done;
			end
		end else if (pix.ready) begin
			if (done_q || (k_q == 2'd3)) begin
				act_q <= 1'b0;
			end else begin
				k_q <= k_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!act_q && ctl.load) begin
			x_q   <= x;
			y_q   <= y;
			cx_q  <= cx;
			cy_q  <= cy;
			col_q <= col;
		end
	end

	assign plus_x = (k_q == 2'd0) || (k_q == 2'd3);
	assign plus_y = (k_q == 2'd0) || (k_q == 2'd2);
	assign sx     = plus_x ? (SW'(cx_q) + SW'(x_q)) : (SW'(cx_q) - SW'(x_q));
	assign sy     = plus_y ? (SW'(cy_q) + SW'(y_q)) : (SW'(cy_q) - SW'(y_q));

	assign busy         = act_q;
	assign pix.valid    = act_q;
	assign pix.pixel_x  = done_q ? '0 : sx[PW-1:0];
	assign pix.pixel_y  = done_q ? '0 : sy[PW-1:0];
	assign pix.color    = done_q ? '0 : col_q;
	assign pix.last     = done_q || (k_q == 2'd3);
	assign pix.done_res = done_q;

endmodule

// File: rtl/meg_chk.sv
module meg_chk import meg_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      step_valid,
	input logic                      step_ready,
	input logic                      pix_valid,
	input logic                      pix_ready,
	input logic signed [COORD_BITS:0] pix_x,
	input logic signed [COORD_BITS:0] pix_y,
	input logic                      pix_last,
	input logic                      pix_done
);

	a_step_busy: assert property (@(posedge clk) disable iff (!arst_n)
		step_valid && step_ready |=> !step_ready)
		else $error("step ready right after an accepted item");

	a_done_item: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && pix_done |-> pix_last && (pix_x == '0) && (pix_y == '0))
		else $error("done item without last or with coordinates");

	a_group_cont: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && pix_ready && !pix_last |=> pix_valid)
		else $error("pixel group broken before last item");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && !pix_ready |=> pix_valid && $stable(pix_x) && $stable(pix_y)
		&& $stable(pix_last))
		else $error("output item changed while stalled");

endmodule

bind midpoint_ellipse_generator meg_chk #(.COORD_BITS(COORD_BITS)) u_meg_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.step_valid (step.valid),
	.step_ready (step.ready),
	.pix_valid  (pix.valid),
	.pix_ready  (pix.ready),
	.pix_x      (pix.pixel_x),
	.pix_y      (pix.pixel_y),
	.pix_last   (pix.last),
	.pix_done   (pix.done_res)
);

// File: dv/midpoint_ellipse_generator_test.sv
`timescale 1ns / 100ps

module midpoint_ellipse_generator_test;
	import meg_pkg::*;

	localparam int SETTLE_CYCLES  = 25;
	localparam int HOLD_CYCLES    = 300;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RANDOM_ITEMS   = 150;
	localparam int CFG_IDX_TOP    = (1 << CFG_IDX_W) - 1;

	typedef struct packed {
		logic signed [COORD_BITS_DEF:0] px;
		logic signed [COORD_BITS_DEF:0] py;
		logic [COLOR_W-1:0]             color;
		logic                           last;
		logic                           done;
	} pix_t;

	class ellipse_ledger;
		logic [CFG_DATA_W-1:0] center_x, center_y, radius_x, radius_y, pixel_color;
		int     off_x, off_y;
		longint dec;
		bit     region_two, finished;
		pix_t   pending_pixels[$];
		int     fails, reported;

		function new();
			center_x = 0;
			center_y = 0;
			radius_x = 0;
			radius_y = 0;
			pixel_color = 0;
			off_x = 0;
			off_y = 0;
			dec = 0;
			region_two = 0;
			finished = 1;
			fails = 0;
			reported = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			case (idx)
				REG_CENTER_X: center_x = val;
				REG_CENTER_Y: center_y = val;
				REG_RADIUS_X: radius_x = val;
				REG_RADIUS_Y: radius_y = val;
				REG_PIXEL_COLOR: pixel_color = val;
				default: ;
			endcase
		endfunction

		function void add_pixel(longint px, longint py, logic [COLOR_W-1:0] col, bit lst, bit dn);
			pix_t p;
			p.px = px[COORD_BITS_DEF:0];
			p.py = py[COORD_BITS_DEF:0];
			p.color = col;
			p.last = lst;
			p.done = dn;
			pending_pixels.push_back(p);
		endfunction

		function void predict_step(bit restart);
			longint rx, ry, rx2, ry2, cx, cy, x, y;
			logic signed [COORD_BITS_DEF-1:0] cxs, cys;
			logic [COLOR_W-1:0] col;
			rx = radius_x[RADIUS_BITS_DEF-1:0];
			ry = radius_y[RADIUS_BITS_DEF-1:0];
			rx2 = rx * rx;
			ry2 = ry * ry;
			cxs = center_x[COORD_BITS_DEF-1:0];
			cys = center_y[COORD_BITS_DEF-1:0];
			cx = cxs;
			cy = cys;
			col = pixel_color[COLOR_W-1:0];
			if (restart) begin
				off_x = 0;
				off_y = int'(ry);
				dec = 4 * ry2 - 4 * rx2 * ry + rx2;
				region_two = 0;
				finished = 0;
			end
			if (!finished && !region_two) begin
				x = off_x;
				y = off_y;
				if (!(y >= 0 && 2 * ry2 * x <= 2 * rx2 * y)) begin
					region_two = 1;
					dec = ry2 * (2 * x + 1) * (2 * x + 1) + 4 * rx2 * (y - 1) * (y - 1)
						- 4 * rx2 * ry2;
				end
			end
			if (!finished && region_two && off_y < 0)
				finished = 1;
			if (finished) begin
				add_pixel(0, 0, '0, 1, 1);
				return;
			end
			x = off_x;
			y = off_y;
			add_pixel(cx + x, cy + y, col, 0, 0);
			add_pixel(cx - x, cy - y, col, 0, 0);
			add_pixel(cx - x, cy + y, col, 0, 0);
			add_pixel(cx + x, cy - y, col, 1, 0);
			if (!region_two) begin
				x = x + 1;
				if (dec < 0) begin
					dec = dec + 8 * ry2 * x + 4 * ry2;
				end else begin
					y = y - 1;
					dec = dec + 8 * ry2 * x - 8 * rx2 * y + 4 * ry2;
				end
			end else begin
				y = y - 1;
				if (dec <= 0) begin
					x = x + 1;
					dec = dec + 8 * ry2 * x - 8 * rx2 * y + 4 * rx2;
				end else begin
					dec = dec + 4 * rx2 - 8 * rx2 * y;
				end
			end
			off_x = int'(x);
			off_y = int'(y);
		endfunction

		function void note_failure(string msg);
			fails++;
			if (reported < 10) begin
				reported++;
				$display("mismatch: %s", msg);
			end
		endfunction

		function void compare(string field, longint want, longint got);
			if (want != got)
				note_failure($sformatf("%s expected %0d, got %0d", field, want, got));
		endfunction

		function void check_pixel(pix_t got);
			pix_t want;
			if (pending_pixels.size() == 0) begin
				note_failure($sformatf("unexpected item x=%0d y=%0d done=%0b",
					got.px, got.py, got.done));
				return;
			end
			want = pending_pixels.pop_front();
			compare("pixel_x", want.px, got.px);
			compare("pixel_y", want.py, got.py);
			compare("color", want.color, got.color);
			compare("last", want.last, got.last);
			compare("done_res", want.done, got.done);
		endfunction

		function int pending();
			return pending_pixels.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	bit   tx_calm, rx_calm, rx_hold;
	int   quiet_cycles;
	ellipse_ledger ledger;

	meg_cfg_if  cfg_ch ();
	meg_step_if step_ch ();
	meg_pix_if  pix_ch ();

	midpoint_ellipse_generator dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.step   (step_ch),
		.pix    (pix_ch)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		pix_t got;
		if (arst_n) begin
			if (cfg_ch.valid && cfg_ch.ready)
				ledger.write_reg(cfg_ch.index, cfg_ch.data);
			if (step_ch.valid && step_ch.ready)
				ledger.predict_step(step_ch.restart);
			if (pix_ch.valid && pix_ch.ready) begin
				got.px = pix_ch.pixel_x;
				got.py = pix_ch.pixel_y;
				got.color = pix_ch.color;
				got.last = pix_ch.last;
				got.done = pix_ch.done_res;
				ledger.check_pixel(got);
			end
		end
	end

	always @(posedge clk) begin
		if ((cfg_ch.valid && cfg_ch.ready) || (step_ch.valid && step_ch.ready)
				|| (pix_ch.valid && pix_ch.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		forever begin
			@(posedge clk);
			if (rx_hold) begin
				pix_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				rx_hold = 0;
			end else if (rx_calm) begin
				pix_ch.ready <= 1'b1;
			end else begin
				pix_ch.ready <= ($urandom_range(99) >= 35);
			end
		end
	end

	task automatic send_step(input bit restart);
		int gap;
		gap = 0;
		if (!tx_calm)
			while ($urandom_range(99) < 35)
				gap++;
		if (gap > 0) begin
			step_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		step_ch.valid <= 1'b1;
		step_ch.restart <= restart;
		do @(posedge clk); while (!step_ch.ready);
	endtask

	task automatic settle();
		step_ch.valid <= 1'b0;
		do @(posedge clk); while (ledger.pending() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= val;
		do @(posedge clk); while (!cfg_ch.ready);
	endtask

	task automatic set_ellipse(input logic [CFG_DATA_W-1:0] cx, cy, rx, ry, col);
		cfg_write(REG_CENTER_X, cx);
		cfg_write(REG_CENTER_Y, cy);
		cfg_write(REG_RADIUS_X, rx);
		cfg_write(REG_RADIUS_Y, ry);
		cfg_write(REG_PIXEL_COLOR, col);
		cfg_ch.valid <= 1'b0;
	endtask

	function automatic logic [CFG_DATA_W-1:0] pick_radius();
		logic [CFG_DATA_W-1:0] r;
		if ($urandom_range(7) == 0)
			r = CFG_DATA_W'($urandom_range(0, (1 << RADIUS_BITS_DEF) - 1));
		else
			r = CFG_DATA_W'($urandom_range(0, 12));
		if ($urandom_range(3) == 0)
			r[CFG_DATA_W-1:RADIUS_BITS_DEF] = (CFG_DATA_W - RADIUS_BITS_DEF)'($urandom);
		return r;
	endfunction

	task automatic random_config(input bit all_regs);
		bit wrote;
		wrote = 0;
		if (all_regs || $urandom_range(4) != 0) begin
			cfg_write(REG_CENTER_X, CFG_DATA_W'($urandom));
			wrote = 1;
		end
		if (all_regs || $urandom_range(4) != 0) begin
			cfg_write(REG_CENTER_Y, CFG_DATA_W'($urandom));
			wrote = 1;
		end
		if (all_regs || $urandom_range(4) != 0) begin
			cfg_write(REG_RADIUS_X, pick_radius());
			wrote = 1;
		end
		if (all_regs || $urandom_range(4) != 0) begin
			cfg_write(REG_RADIUS_Y, pick_radius());
			wrote = 1;
		end
		if (all_regs || $urandom_range(4) != 0) begin
			cfg_write(REG_PIXEL_COLOR, CFG_DATA_W'($urandom));
			wrote = 1;
		end
		if ($urandom_range(4) == 0) begin
			cfg_write(CFG_IDX_W'($urandom_range(REG_PIXEL_COLOR + 1, CFG_IDX_TOP)),
				CFG_DATA_W'($urandom));
			wrote = 1;
		end
		if (wrote)
			cfg_ch.valid <= 1'b0;
	endtask

	initial begin
		int  rand_items, len, phase;
		bit  lead_restart;
		ledger = new();
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.data = '0;
		step_ch.valid = 1'b0;
		step_ch.restart = 1'b0;
		pix_ch.ready = 1'b0;
		tx_calm = 0;
		rx_calm = 0;
		rx_hold = 0;
		quiet_cycles = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// advance before any restart, then a point ellipse from reset values
		send_step(1'b0);
		send_step(1'b0);
		send_step(1'b1);
		send_step(1'b0);
		send_step(1'b0);
		settle();

		set_ellipse(16'hF800, 16'h07FF, 16'h03FF, 16'h03FF, 16'h00FF);
		send_step(1'b1);
		repeat (3) send_step(1'b0);
		settle();

		// upper bits set beyond the register widths; also an unused index
		set_ellipse(16'h57FF, 16'h3800, 16'hFC03, 16'h0402, 16'hAB5A);
		cfg_write(CFG_IDX_W'(REG_PIXEL_COLOR + 1), 16'hFFFF);
		cfg_ch.valid <= 1'b0;
		send_step(1'b1);
		repeat (12) send_step(1'b0);
		settle();

		rand_items = 0;
		phase = 0;
		while (rand_items < RANDOM_ITEMS || phase <= 5) begin
			tx_calm = (phase == 3 || phase == 5);
			rx_calm = (phase == 3);
			if (phase == 0 || $urandom_range(3) != 0)
				random_config(phase == 0);
			lead_restart = ($urandom_range(99) < 85);
			len = (phase == 5) ? 30 : $urandom_range(6, 36);
			if (phase == 5)
				rx_hold = 1;
			for (int k = 0; k < len; k++) begin
				send_step((k == 0 && lead_restart) || $urandom_range(99) < 3);
				rand_items++;
			end
			settle();
			phase++;
		end

		if (ledger.pending() != 0)
			ledger.note_failure($sformatf("%0d items never arrived", ledger.pending()));
		if (ledger.fails == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// File: filelist.f
rtl/meg_pkg.sv
rtl/meg_intf.sv
rtl/meg_mul.sv
rtl/meg_seq.sv
rtl/meg_emit.sv
rtl/midpoint_ellipse_generator.sv
rtl/meg_chk.sv
dv/midpoint_ellipse_generator_test.sv
